### hdl/fpa_pkg.sv
// Types, operation codes and saturation helpers for the fixed-point ALU.
// No dependencies.
`default_nettype none
package fpa_pkg;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_GT     = 4'd4,
        MODE_LT     = 4'd5,
        MODE_GE     = 4'd6,
        MODE_LE     = 4'd7,
        MODE_NE     = 4'd8,
        MODE_EQ     = 4'd9,
        MODE_MIN    = 4'd10,
        MODE_MAX    = 4'd11,
        MODE_INC    = 4'd12,
        MODE_DEC    = 4'd13,
        MODE_TO_INT = 4'd14,
        MODE_NONE   = 4'd15
    } t_mode;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OVF  = 2'd1;
    localparam logic [1:0] STATUS_DIV0 = 2'd2;

    localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] RAW_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] res;
    } t_res;

    typedef struct packed {
        logic        valid;
        t_mode       mode;
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  status;
        logic        div_go;
    } t_side;

    // sign + magnitude to raw, saturating
    function automatic t_res sat_mag(input logic neg, input logic [63:0] mag);
        t_res r;
        r.status = STATUS_OK;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                r.status = STATUS_OVF;
                r.res    = RAW_MIN;
            end else begin
                r.res = 32'd0 - mag[31:0];
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                r.status = STATUS_OVF;
                r.res    = RAW_MAX;
            end else begin
                r.res = mag[31:0];
            end
        end
        return r;
    endfunction

    // 33-bit exact sum to raw, saturating
    function automatic t_res sat33(input logic [32:0] s);
        t_res r;
        r.status = STATUS_OK;
        r.res    = s[31:0];
        if (s[32] != s[31]) begin
            r.status = STATUS_OVF;
            r.res    = s[32] ? RAW_MIN : RAW_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/fixed_point_alu.sv
// Channel   Handshake          Payload
// command   start / busy       i_mode, i_operand_a, i_operand_b
// result    o_done (strobe)    o_result, o_compare_true, o_status
//
// One command per cycle. The radix-2 divider sets the depth of the pipeline
// from accept to o_done: one quotient bit per stage over 32 + FRAC_BITS
// stages. All modes pass through the same depth so results stay in order.
// busy is always low. Synchronous reset empties the pipeline.
//
// Fixed-point ALU top level: deep pipeline with multiplier and divider.
// Depends on fpa_pkg.
`default_nettype none
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [3:0]  i_mode,
    input  wire  [31:0] i_operand_a,
    input  wire  [31:0] i_operand_b,
    output logic        o_done,
    output logic [31:0] o_result,
    output logic        o_compare_true,
    output logic [1:0]  o_status
);
    localparam int NW = 32 + FRAC_BITS;
    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    // input stage
    logic               r_v_a;
    fpa_pkg::t_mode     r_mode_a;
    logic signed [31:0] r_a, r_b;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
        end else begin
            r_v_a <= start && !busy;
        end
        r_mode_a <= fpa_pkg::t_mode'(i_mode);
        r_a      <= i_operand_a;
        r_b      <= i_operand_b;
    end

    // simple ops
    logic [31:0]   mag_a, mag_b, toi_q;
    logic [32:0]   ext_a, ext_b;
    fpa_pkg::t_res simple;
    logic          cmp;
    fpa_pkg::t_side n_side0;

    always_comb begin
        ext_a  = {r_a[31], r_a};
        ext_b  = {r_b[31], r_b};
        mag_a  = r_a[31] ? (32'd0 - r_a) : r_a;
        mag_b  = r_b[31] ? (32'd0 - r_b) : r_b;
        toi_q  = mag_a >> FRAC_BITS;
        simple = '{status: fpa_pkg::STATUS_OK, res: 32'd0};
        cmp    = 1'b0;
        unique case (r_mode_a)
            fpa_pkg::MODE_ADD:    simple = fpa_pkg::sat33(ext_a + ext_b);
            fpa_pkg::MODE_SUB:    simple = fpa_pkg::sat33(ext_a - ext_b);
            fpa_pkg::MODE_MUL:    simple = '{status: fpa_pkg::STATUS_OK, res: 32'd0};
            fpa_pkg::MODE_DIV: begin
                if (r_b == 0) begin
                    simple.status = fpa_pkg::STATUS_DIV0;
                    simple.res    = (r_a > 0) ? fpa_pkg::RAW_MAX :
                                    (r_a < 0) ? fpa_pkg::RAW_MIN : 32'd0;
                end
            end
            fpa_pkg::MODE_GT:     cmp = r_a > r_b;
            fpa_pkg::MODE_LT:     cmp = r_a < r_b;
            fpa_pkg::MODE_GE:     cmp = r_a >= r_b;
            fpa_pkg::MODE_LE:     cmp = r_a <= r_b;
            fpa_pkg::MODE_NE:     cmp = r_a != r_b;
            fpa_pkg::MODE_EQ:     cmp = r_a == r_b;
            fpa_pkg::MODE_MIN:    simple.res = (r_a > r_b) ? r_b : r_a;
            fpa_pkg::MODE_MAX:    simple.res = (r_a < r_b) ? r_b : r_a;
            fpa_pkg::MODE_INC:    simple = fpa_pkg::sat33(ext_a + 33'd1);
            fpa_pkg::MODE_DEC:    simple = fpa_pkg::sat33(ext_a - 33'd1);
            fpa_pkg::MODE_TO_INT: simple.res = r_a[31] ? (32'd0 - toi_q) : toi_q;
            default: begin
                simple = '{status: fpa_pkg::STATUS_OK, res: 32'd0};
                cmp    = 1'b0;
            end
        endcase
        n_side0.valid  = r_v_a;
        n_side0.mode   = r_mode_a;
        n_side0.res    = simple.res;
        n_side0.cmp    = cmp;
        n_side0.status = simple.status;
        n_side0.div_go = (r_mode_a == fpa_pkg::MODE_DIV) && (r_b != 0);
    end

    // side line carries non-divide results alongside the divider
    fpa_pkg::t_side r_side [0:NW+1];

    // multiplier: product, round, saturate
    logic signed [63:0] r_prod;
    logic [63:0]        r_mq;
    logic               r_mneg;
    logic [63:0]        prod_mag;
    fpa_pkg::t_res      mul_res;

    assign prod_mag = r_prod[63] ? (64'd0 - r_prod) : r_prod;
    assign mul_res  = fpa_pkg::sat_mag(r_mneg, r_mq);

    always_ff @(posedge i_clk) begin
        r_prod <= r_a * r_b;
        r_mq   <= (prod_mag + HALF) >> FRAC_BITS;
        r_mneg <= r_prod[63];
    end

    fpa_pkg::t_side n_side2;

    always_comb begin
        n_side2 = r_side[1];
        if (r_side[1].mode == fpa_pkg::MODE_MUL) begin
            n_side2.res    = mul_res.res;
            n_side2.status = mul_res.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW + 1; k++) begin
                r_side[k] <= '0;
            end
        end else begin
            r_side[0] <= n_side0;
            r_side[1] <= r_side[0];
            r_side[2] <= n_side2;
            for (int k = 3; k <= NW + 1; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // divider: one quotient bit per stage
    logic [31:0]   r_rem [0:NW];
    logic [NW-1:0] r_num [0:NW];
    logic [NW-1:0] r_q   [0:NW];
    logic [31:0]   r_den [0:NW];
    logic          r_neg [0:NW];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= 32'd0;
        r_num[0] <= {mag_a, FRAC_BITS'(0)};
        r_q[0]   <= '0;
        r_den[0] <= mag_b;
        r_neg[0] <= r_a[31] ^ r_b[31];
    end

    for (genvar k = 1; k <= NW; k++) begin : g_div
        logic [32:0] trial;
        logic        fits;
        assign trial = {r_rem[k-1], r_num[k-1][NW-1]};
        assign fits  = trial >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            r_rem[k] <= fits ? 32'(trial - {1'b0, r_den[k-1]}) : trial[31:0];
            r_num[k] <= {r_num[k-1][NW-2:0], 1'b0};
            r_q[k]   <= {r_q[k-1][NW-2:0], fits};
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
        end
    end

    // round half away from zero
    logic [NW:0]   r_dq;
    logic          r_dneg;
    fpa_pkg::t_res div_res;

    always_ff @(posedge i_clk) begin
        r_dq   <= {1'b0, r_q[NW]} +
                  (NW+1)'({r_rem[NW], 1'b0} >= {1'b0, r_den[NW]});
        r_dneg <= r_neg[NW];
    end

    assign div_res = fpa_pkg::sat_mag(r_dneg, 64'(r_dq));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_side[NW+1].valid;
        end
        o_compare_true <= r_side[NW+1].cmp;
        if (r_side[NW+1].div_go) begin
            o_result <= div_res.res;
            o_status <= div_res.status;
        end else begin
            o_result <= r_side[NW+1].res;
            o_status <= r_side[NW+1].status;
        end
    end

endmodule
`default_nettype wire

### hdl/fpa_checker.sv
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg.
`default_nettype none
module fpa_checker #(
    parameter int FRAC_BITS = 8
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_done,
    input wire [31:0] o_result,
    input wire        o_compare_true,
    input wire [1:0]  o_status
);
    localparam int LAT = FRAC_BITS + 36;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result beat missing after accept");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == fpa_pkg::STATUS_OK || o_status == fpa_pkg::STATUS_OVF ||
                    o_status == fpa_pkg::STATUS_DIV0))
        else $error("bad status code");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_compare_true) |-> (o_result == 32'd0 &&
                                        o_status == fpa_pkg::STATUS_OK))
        else $error("compare beat with nonzero result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !$past(o_done)) |-> $past(start && !busy, LAT))
        else $error("result beat without command");

endmodule

bind fixed_point_alu fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_result       (o_result),
    .o_compare_true (o_compare_true),
    .o_status       (o_status)
);
`default_nettype wire

### tb/fixed_point_alu_tb.sv
// Self-checking testbench for fixed_point_alu: drives random and corner commands,
// predicts each result in a scoreboard class and compares every o_done beat.
// Depends on fpa_pkg and fixed_point_alu.
`timescale 1ns / 1ps
module fixed_point_alu_tb;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 36;

    typedef struct {
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  status;
    } t_alu_out;

    class t_scoreboard;
        t_alu_out pending[$];
        int errors = 0;

        function automatic logic [31:0] clamp(input logic neg, input logic [63:0] mag,
                                              inout logic [1:0] st);
            if (neg) begin
                if (mag > 64'h8000_0000) begin
                    st = fpa_pkg::STATUS_OVF;
                    return fpa_pkg::RAW_MIN;
                end
                return 32'd0 - mag[31:0];
            end
            if (mag > 64'h7FFF_FFFF) begin
                st = fpa_pkg::STATUS_OVF;
                return fpa_pkg::RAW_MAX;
            end
            return mag[31:0];
        endfunction

        function automatic logic [31:0] clamp_wide(input longint v, inout logic [1:0] st);
            logic [63:0] m;
            m = (v < 0) ? -v : v;
            return clamp(v < 0, m, st);
        endfunction

        function automatic void note_command(input fpa_pkg::t_mode m,
                                             input logic [31:0] ra,
                                             input logic [31:0] rb);
            t_alu_out e;
            longint a, b, p;
            logic [63:0] q, num, den;
            a = longint'($signed(ra));
            b = longint'($signed(rb));
            e.res = '0;
            e.cmp = 1'b0;
            e.status = fpa_pkg::STATUS_OK;
            case (m)
                fpa_pkg::MODE_ADD: e.res = clamp_wide(a + b, e.status);
                fpa_pkg::MODE_SUB: e.res = clamp_wide(a - b, e.status);
                fpa_pkg::MODE_MUL: begin
                    p = a * b;
                    q = (((p < 0) ? -p : p) + (64'd1 << (FRAC - 1))) >> FRAC;
                    e.res = clamp(p < 0, q, e.status);
                end
                fpa_pkg::MODE_DIV: begin
                    if (b == 0) begin
                        e.status = fpa_pkg::STATUS_DIV0;
                        e.res = (a > 0) ? fpa_pkg::RAW_MAX :
                                ((a < 0) ? fpa_pkg::RAW_MIN : 32'd0);
                    end else begin
                        num = ((a < 0) ? -a : a) << FRAC;
                        den = (b < 0) ? -b : b;
                        q = (2 * num + den) / (2 * den);
                        e.res = clamp((a < 0) != (b < 0), q, e.status);
                    end
                end
                fpa_pkg::MODE_GT: e.cmp = a > b;
                fpa_pkg::MODE_LT: e.cmp = a < b;
                fpa_pkg::MODE_GE: e.cmp = a >= b;
                fpa_pkg::MODE_LE: e.cmp = a <= b;
                fpa_pkg::MODE_NE: e.cmp = a != b;
                fpa_pkg::MODE_EQ: e.cmp = a == b;
                fpa_pkg::MODE_MIN: e.res = (a > b) ? rb : ra;
                fpa_pkg::MODE_MAX: e.res = (a < b) ? rb : ra;
                fpa_pkg::MODE_INC: e.res = clamp_wide(a + 1, e.status);
                fpa_pkg::MODE_DEC: e.res = clamp_wide(a - 1, e.status);
                fpa_pkg::MODE_TO_INT: begin
                    q = ((a < 0) ? -a : a) >> FRAC;
                    e.res = clamp(a < 0, q, e.status);
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function automatic void check_result(input logic [31:0] res, input logic cmp,
                                             input logic [1:0] st);
            t_alu_out e;
            if (pending.size() == 0) begin
                $error("unexpected result beat: result %h", res);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (res !== e.res) begin
                $error("result: expected %h, actual %h", e.res, res);
                errors++;
            end
            if (cmp !== e.cmp) begin
                $error("compare_true: expected %b, actual %b", e.cmp, cmp);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [3:0]  i_mode = '0;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    wire         busy;
    wire         o_done;
    wire  [31:0] o_result;
    wire         o_compare_true;
    wire  [1:0]  o_status;

    t_scoreboard alu_sb = new();
    int gap_pct = 17;

    always #5 i_clk = ~i_clk;

    fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_done(o_done), .o_result(o_result), .o_compare_true(o_compare_true),
        .o_status(o_status)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            alu_sb.check_result(o_result, o_compare_true, o_status);
        end
        if (i_rst_n && start && !busy) begin
            alu_sb.note_command(fpa_pkg::t_mode'(i_mode), i_operand_a, i_operand_b);
        end
    end

    task automatic send_command(input logic [3:0] m, input logic [31:0] a,
                                input logic [31:0] b);
        while ($urandom_range(99, 0) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_mode      <= m;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7, 0))
            0: return fpa_pkg::RAW_MAX - $urandom_range(3, 0);
            1: return fpa_pkg::RAW_MIN + $urandom_range(3, 0);
            2: return $urandom_range(4, 0) - 2;
            3: return $urandom_range(1 << 20, 0) - (1 << 19);
            4: return 32'($signed($urandom_range(65535, 0)) - 32768) << FRAC;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int n = 0; n < count; n++) begin
            a = pick_operand();
            b = ($urandom_range(9, 0) == 0) ? a : pick_operand();
            if ($urandom_range(15, 0) == 0) b = 32'd0;
            send_command(4'($urandom_range(15, 0)), a, b);
        end
    endtask

    initial begin
        int waited;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int m = 0; m < 16; m++) begin
            send_command(4'(m), fpa_pkg::RAW_MAX, fpa_pkg::RAW_MIN);
        end
        send_command(fpa_pkg::MODE_ADD, fpa_pkg::RAW_MAX, 32'd1);
        send_command(fpa_pkg::MODE_SUB, fpa_pkg::RAW_MIN, 32'd1);
        send_command(fpa_pkg::MODE_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        send_command(fpa_pkg::MODE_MUL, 32'h0000_0001, 32'h0000_0080);
        send_command(fpa_pkg::MODE_MUL, fpa_pkg::RAW_MIN, fpa_pkg::RAW_MIN);
        send_command(fpa_pkg::MODE_DIV, 32'h0000_0100, 32'd0);
        send_command(fpa_pkg::MODE_DIV, 32'hFFFF_FF00, 32'd0);
        send_command(fpa_pkg::MODE_DIV, 32'd0, 32'd0);
        send_command(fpa_pkg::MODE_DIV, fpa_pkg::RAW_MIN, 32'hFFFF_FFFF);
        send_command(fpa_pkg::MODE_INC, fpa_pkg::RAW_MAX, 32'd0);
        send_command(fpa_pkg::MODE_DEC, fpa_pkg::RAW_MIN, 32'd0);
        send_command(fpa_pkg::MODE_TO_INT, 32'hFFFF_FE80, 32'd0);

        gap_pct = 17;
        run_random(200);
        gap_pct = 80;
        run_random(200);
        gap_pct = 0;
        run_random(200);
        start <= 1'b0;

        waited = 0;
        while (alu_sb.pending.size() != 0 && waited < 10 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (alu_sb.errors == 0 && alu_sb.pending.size() == 0) begin
            $display("[fixed_point_alu] OK");
        end else begin
            $display("[fixed_point_alu] ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("[fixed_point_alu] ERROR");
        $finish;
    end
endmodule
